@@ design/exception_entry_and_status_restore_macros.svh @@
// assertion macros for the exception entry and status restore block
// used by the top level only, relies on nothing else
`ifndef EXCEPTION_ENTRY_AND_STATUS_RESTORE_MACROS_SVH
`define EXCEPTION_ENTRY_AND_STATUS_RESTORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define EESR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eesr assertion failed");

// next-cycle implication, checked outside reset
`define EESR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eesr assertion failed");

`endif

@@ design/eesr_pkg.sv @@
// shared types and constants for the exception entry and status restore block
// no dependencies
`timescale 1ns / 1ps

package eesr_pkg;

    // levels 0..LEVEL_COUNT-1, banks for levels 1..3
    localparam int LEVEL_COUNT = 4;
    localparam int LEVEL_W     = 2;
    localparam int BANK_DEPTH  = 3;
    localparam int BANK_AW     = 2;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(LEVEL_COUNT - 1);

    // configuration register indexes
    localparam int CFG_COUNT = 3;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 64;
    localparam logic [CFG_AW-1:0] CFG_VBASE_L1 = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_VBASE_L2 = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_VBASE_L3 = 2'd2;

    // request codes
    localparam logic OP_TAKE    = 1'b0;
    localparam logic OP_RESTORE = 1'b1;

    // vector offset is below 2^11, so it fills the cleared low bits of the base
    localparam int VEC_LOW_W = 11;

    localparam int IN_DATA_W  = 232;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USED_W = 109;

    // input word, members listed from the top bit down
    typedef struct packed {
        logic [31:0] status_word;
        logic [3:0]  current_masks;
        logic [3:0]  current_flags;
        logic [63:0] return_address;
        logic [63:0] fault_address;
        logic [63:0] syndrome;
    } t_in_data;

    typedef struct packed {
        logic [1:0] exception_kind;
        logic       op;
    } t_in_user;

    typedef struct packed {
        t_in_user user;
        t_in_data data;
    } t_in_item;

    // result word, members listed from the top bit down
    typedef struct packed {
        logic               level_changed;
        logic               clear_exclusive;
        logic [31:0]        packed_status;
        logic [3:0]         new_masks;
        logic [3:0]         new_flags;
        logic               new_stack_select;
        logic [LEVEL_W-1:0] new_level;
        logic [63:0]        vector_address;
    } t_result;

    // architectural level and stack select
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               stack_select;
    } t_arch_state;

    // bank write request for one level slot
    typedef struct packed {
        logic               en;
        logic [BANK_AW-1:0] slot;
        logic [31:0]        status;
        logic [63:0]        link;
        logic [63:0]        syndrome;
        logic [63:0]        fault;
    } t_bank_wr;

    typedef struct packed {
        logic [CFG_COUNT-1:0][CFG_DW-1:0] base;
    } t_vec_bases;

endpackage

@@ design/eesr_cfg_regs.sv @@
// vector base registers written through the plain configuration port
// depends on eesr_pkg
`timescale 1ns / 1ps

module eesr_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [eesr_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [eesr_pkg::CFG_DW-1:0] i_cfg_wr_data,
    output eesr_pkg::t_vec_bases       o_bases
);

    eesr_pkg::t_vec_bases r_bases;

    // register writes, an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bases <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                eesr_pkg::CFG_VBASE_L1: r_bases.base[0] <= i_cfg_wr_data;
                eesr_pkg::CFG_VBASE_L2: r_bases.base[1] <= i_cfg_wr_data;
                eesr_pkg::CFG_VBASE_L3: r_bases.base[2] <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign o_bases = r_bases;

endmodule

@@ design/eesr_entry_calc.sv @@
// combinational take and restore logic: next level, status word, vector address
// depends on eesr_pkg
`timescale 1ns / 1ps

module eesr_entry_calc (
    input  eesr_pkg::t_in_item    i_item,
    input  eesr_pkg::t_arch_state i_state,
    input  eesr_pkg::t_vec_bases  i_bases,
    output eesr_pkg::t_arch_state o_next_state,
    output eesr_pkg::t_result     o_result,
    output eesr_pkg::t_bank_wr    o_bank_wr
);

    logic                             entry_from_l0;
    logic [eesr_pkg::LEVEL_W-1:0]     target;
    logic [31:0]                      packed_sw;
    logic [eesr_pkg::VEC_LOW_W-1:0]   vec_off;
    logic [63:0]                      base_sel;
    logic [eesr_pkg::LEVEL_W-1:0]     rst_level;

    // target level is max(1, current), so a lower entry means level 0
    assign entry_from_l0 = (i_state.level == '0);
    assign target        = entry_from_l0 ? eesr_pkg::LEVEL_W'(1) : i_state.level;

    // status word: NZCV at 31:28, DAIF at 9:6, level at 3:2, stack select at 0
    assign packed_sw = {i_item.data.current_flags, 18'd0, i_item.data.current_masks, 2'd0,
                        i_state.level, 1'b0, i_state.stack_select};

    // offset: lower 0x400, same level on SP_ELx 0x200, plus kind * 0x80
    assign vec_off = {entry_from_l0, ~entry_from_l0 & i_state.stack_select,
                      i_item.user.exception_kind, 7'd0};

    // base of the target level, target is never 0
    always_comb begin
        unique case (target)
            2'd1:    base_sel = i_bases.base[0];
            2'd2:    base_sel = i_bases.base[1];
            default: base_sel = i_bases.base[2];
        endcase
    end

    // restored level saturates at the top level
    assign rst_level = (i_item.data.status_word[3:2] > eesr_pkg::MAX_LEVEL) ?
                       eesr_pkg::MAX_LEVEL : i_item.data.status_word[3:2];

    always_comb begin
        o_bank_wr.slot     = eesr_pkg::BANK_AW'(target - eesr_pkg::LEVEL_W'(1));
        o_bank_wr.status   = packed_sw;
        o_bank_wr.link     = i_item.data.return_address;
        o_bank_wr.syndrome = i_item.data.syndrome;
        o_bank_wr.fault    = i_item.data.fault_address;
        unique case (i_item.user.op)
            eesr_pkg::OP_TAKE: begin
                o_bank_wr.en                = 1'b1;
                o_next_state.level          = target;
                o_next_state.stack_select   = 1'b1;
                o_result.vector_address     = {base_sel[63:eesr_pkg::VEC_LOW_W], vec_off};
                o_result.new_flags          = i_item.data.current_flags;
                o_result.new_masks          = 4'hf;
                o_result.packed_status      = packed_sw;
                o_result.clear_exclusive    = 1'b1;
            end
            default: begin
                o_bank_wr.en                = 1'b0;
                o_next_state.level          = rst_level;
                o_next_state.stack_select   = i_item.data.status_word[0];
                o_result.vector_address     = '0;
                o_result.new_flags          = i_item.data.status_word[31:28];
                o_result.new_masks          = i_item.data.status_word[9:6];
                o_result.packed_status      = '0;
                o_result.clear_exclusive    = 1'b0;
            end
        endcase
        o_result.new_level        = o_next_state.level;
        o_result.new_stack_select = o_next_state.stack_select;
        o_result.level_changed    = (o_next_state.level != i_state.level);
    end

endmodule

@@ design/exception_entry_and_status_restore.sv @@
// Exception entry and status restore. Each word is a take or a restore request; one result word
// comes out per request, in order, through the input register and then the result register. One
// request is accepted every cycle while the output is not stalled: the current level and stack
// select are updated in the single compute stage between the input register and the result
// register, so the next request already sees them. The vector base registers are to be written
// by the user through the configuration port only while no request is in flight; the block
// itself does not enforce it. The saved status, link, syndrome and fault banks for levels 1..3
// are write-only here. Depends on eesr_pkg, eesr_cfg_regs, eesr_entry_calc and the macros header
`timescale 1ns / 1ps
`include "exception_entry_and_status_restore_macros.svh"

module exception_entry_and_status_restore (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // syndrome, fault_address, return_address, current_flags, current_masks, status_word
    input  logic [eesr_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // op, exception_kind
    input  logic [eesr_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    // result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // vector_address, new_level, new_stack_select, new_flags, new_masks, packed_status,
    // clear_exclusive, level_changed, zero fill
    output logic [eesr_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // configuration writes
    input  logic                             i_cfg_wr_en,
    input  logic [eesr_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [eesr_pkg::CFG_DW-1:0]      i_cfg_wr_data
);

    eesr_pkg::t_vec_bases  bases;
    eesr_pkg::t_arch_state r_state;
    eesr_pkg::t_arch_state n_state;
    eesr_pkg::t_result     n_result;
    eesr_pkg::t_result     r_result;
    eesr_pkg::t_bank_wr    bank_wr;
    eesr_pkg::t_in_item    r_item;
    logic                  r_item_valid;
    logic                  r_result_valid;
    logic                  out_free;
    logic                  calc_fire;

    logic [31:0] r_saved_status [eesr_pkg::BANK_DEPTH];
    logic [63:0] r_saved_link   [eesr_pkg::BANK_DEPTH];
    logic [63:0] r_saved_syn    [eesr_pkg::BANK_DEPTH];
    logic [63:0] r_saved_fault  [eesr_pkg::BANK_DEPTH];

    eesr_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_bases       (bases)
    );

    // stage flow: result register frees up when empty or taken
    assign out_free        = !r_result_valid || i_m_axis_tready;
    assign calc_fire       = r_item_valid && out_free;
    assign o_s_axis_tready = !r_item_valid || out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_item_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item.user <= eesr_pkg::t_in_user'(i_s_axis_tuser);
            r_item.data <= eesr_pkg::t_in_data'(i_s_axis_tdata);
        end
    end

    eesr_entry_calc u_calc (
        .i_item       (r_item),
        .i_state      (r_state),
        .i_bases      (bases),
        .o_next_state (n_state),
        .o_result     (n_result),
        .o_bank_wr    (bank_wr)
    );

    // level and stack select move with each computed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (calc_fire) begin
            r_state <= n_state;
        end
    end

    // saved state banks, written on take
    always_ff @(posedge i_clk) begin
        if (calc_fire && bank_wr.en) begin
            r_saved_status[bank_wr.slot] <= bank_wr.status;
            r_saved_link[bank_wr.slot]   <= bank_wr.link;
            r_saved_syn[bank_wr.slot]    <= bank_wr.syndrome;
            r_saved_fault[bank_wr.slot]  <= bank_wr.fault;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else if (out_free) begin
            r_result_valid <= r_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (calc_fire) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_result_valid;
    assign o_m_axis_tdata  = {(eesr_pkg::OUT_DATA_W - eesr_pkg::OUT_USED_W)'(0), r_result};

    // a take leaves the block at a nonzero level on SP_ELx
    `EESR_ASSERT_NEXT(a_take_state, i_clk, i_rst_n, calc_fire && (r_item.user.op == eesr_pkg::OP_TAKE), (r_state.level != '0) && r_state.stack_select)
    // a take result carries all masks set and the new stack select
    `EESR_ASSERT_NOW(a_take_result, i_clk, i_rst_n, r_result_valid && r_result.clear_exclusive, (r_result.new_masks == 4'hf) && r_result.new_stack_select && (r_result.new_level != '0))
    // a restore result carries no vector and no status word
    `EESR_ASSERT_NOW(a_restore_result, i_clk, i_rst_n, r_result_valid && !r_result.clear_exclusive, (r_result.vector_address == '0) && (r_result.packed_status == '0))
    // the level never goes past the top level
    `EESR_ASSERT_NOW(a_level_range, i_clk, i_rst_n, 1'b1, r_state.level <= eesr_pkg::MAX_LEVEL)

endmodule
